FILE: hdl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the swept box collision core.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int STEP_W     = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd1092;

    localparam int HIT_W      = 17;
    localparam int NORM_W     = 2;
    localparam int OUT_W      = 24;   // 22 payload bits padded to bytes

    // time values: 16 fractional bits, saturated to +-2.0, infinities at +-4.0
    localparam int TIME_W     = 20;
    localparam int TIME_FRAC  = 16;
    localparam int QUOT_W     = 17;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_LAT    = DIV_STEPS + 2;
    localparam int EDGE_SHIFT = 15;

    localparam logic signed [TIME_W-1:0] T_ONE = 20'sd65536;
    localparam logic signed [TIME_W-1:0] T_SAT = 20'sd131072;
    localparam logic signed [TIME_W-1:0] T_INF = 20'sd262144;

    typedef logic signed [NORM_W-1:0] norm_t;
    localparam norm_t NORM_POS  = 2'sb01;
    localparam norm_t NORM_NEG  = 2'sb11;
    localparam norm_t NORM_ZERO = 2'sb00;

    typedef struct packed {
        logic broad;        // swept bound touches the other box
        logic overlap_now;
        logic dx_zero;
        logic dx_neg;
        logic dy_zero;
        logic dy_neg;
        logic xin_zero;
        logic xin_neg;
        logic yin_zero;
        logic yin_neg;
        logic xin_thin;     // |x entry distance| below one pixel
        logic yin_thin;
    } side_t;

endpackage

`default_nettype wire

FILE: hdl/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front
// Edges, relative displacement, broadphase and divider operands (4 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module sac_front #(
    parameter int COORD_WIDTH = sac_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sac_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [sac_pkg::STEP_W-1:0]    step_time,
    input  wire logic signed [COORD_WIDTH-1:0] mover_x,
    input  wire logic signed [COORD_WIDTH-1:0] mover_y,
    input  wire logic [COORD_WIDTH-1:0]        mover_width,
    input  wire logic [COORD_WIDTH-1:0]        mover_height,
    input  wire logic signed [COORD_WIDTH-1:0] mover_vel_x,
    input  wire logic signed [COORD_WIDTH-1:0] mover_vel_y,
    input  wire logic signed [COORD_WIDTH-1:0] other_x,
    input  wire logic signed [COORD_WIDTH-1:0] other_y,
    input  wire logic [COORD_WIDTH-1:0]        other_width,
    input  wire logic [COORD_WIDTH-1:0]        other_height,
    input  wire logic signed [COORD_WIDTH-1:0] other_vel_x,
    input  wire logic signed [COORD_WIDTH-1:0] other_vel_y,
    output logic [COORD_WIDTH+16:0]            xin_mag,
    output logic [COORD_WIDTH+16:0]            xout_mag,
    output logic [COORD_WIDTH+16:0]            yin_mag,
    output logic [COORD_WIDTH+16:0]            yout_mag,
    output logic [COORD_WIDTH+16:0]            dx_mag,
    output logic [COORD_WIDTH+16:0]            dy_mag,
    output logic                               xin_qneg,
    output logic                               xout_qneg,
    output logic                               yin_qneg,
    output logic                               yout_qneg,
    output sac_pkg::side_t                     side
);
    import sac_pkg::*;

    localparam int EW = COORD_WIDTH + 2;    // edge, one extra fraction bit
    localparam int VW = COORD_WIDTH + 1;    // velocity difference
    localparam int DW = COORD_WIDTH + 3;    // edge difference
    localparam int MW = COORD_WIDTH + 17;   // magnitude width
    localparam int SW = MW + 1;             // scaled signed width
    localparam logic [63:0] PIXEL = 64'd1 << (FRAC_BITS + TIME_FRAC);

    // stage 1
    logic signed [EW-1:0] ml_reg, mr_reg, mt_reg, mb_reg;
    logic signed [EW-1:0] ol_reg, or_reg, ot_reg, ob_reg;
    logic signed [VW-1:0] dvx_reg, dvy_reg;
    // stage 2
    logic signed [SW-1:0] dx2_reg, dy2_reg;
    logic signed [DW-1:0] ol_mr_reg, or_ml_reg, ot_mb_reg, ob_mt_reg;
    // stage 3
    logic signed [SW-1:0] xin_reg, xout_reg, yin_reg, yout_reg, dx3_reg, dy3_reg;
    logic                 broad_reg, ovl_reg;

    logic signed [EW-1:0] mx2, my2, ox2, oy2;
    logic signed [EW-1:0] mw_e, mh_e, ow_e, oh_e;
    logic signed [SW-1:0] s_ol_mr, s_or_ml, s_ot_mb, s_ob_mt;
    logic signed [SW-1:0] dx_lo, dx_hi, dy_lo, dy_hi;
    logic                 broad_next, ovl_next;
    logic [MW-1:0]        axin, ayin;

    always_comb begin
        mx2  = {mover_x[COORD_WIDTH-1], mover_x, 1'b0};
        my2  = {mover_y[COORD_WIDTH-1], mover_y, 1'b0};
        ox2  = {other_x[COORD_WIDTH-1], other_x, 1'b0};
        oy2  = {other_y[COORD_WIDTH-1], other_y, 1'b0};
        mw_e = $signed({2'b00, mover_width});
        mh_e = $signed({2'b00, mover_height});
        ow_e = $signed({2'b00, other_width});
        oh_e = $signed({2'b00, other_height});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ml_reg  <= mx2 - mw_e;
            mr_reg  <= mx2 + mw_e;
            mt_reg  <= my2 - mh_e;
            mb_reg  <= my2 + mh_e;
            ol_reg  <= ox2 - ow_e;
            or_reg  <= ox2 + ow_e;
            ot_reg  <= oy2 - oh_e;
            ob_reg  <= oy2 + oh_e;
            dvx_reg <= VW'(mover_vel_x) - VW'(other_vel_x);
            dvy_reg <= VW'(mover_vel_y) - VW'(other_vel_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx2_reg   <= dvx_reg * $signed({1'b0, step_time});
            dy2_reg   <= dvy_reg * $signed({1'b0, step_time});
            ol_mr_reg <= DW'(ol_reg) - DW'(mr_reg);
            or_ml_reg <= DW'(or_reg) - DW'(ml_reg);
            ot_mb_reg <= DW'(ot_reg) - DW'(mb_reg);
            ob_mt_reg <= DW'(ob_reg) - DW'(mt_reg);
        end
    end

    always_comb begin
        s_ol_mr = {ol_mr_reg, {EDGE_SHIFT{1'b0}}};
        s_or_ml = {or_ml_reg, {EDGE_SHIFT{1'b0}}};
        s_ot_mb = {ot_mb_reg, {EDGE_SHIFT{1'b0}}};
        s_ob_mt = {ob_mt_reg, {EDGE_SHIFT{1'b0}}};
        dx_lo   = dx2_reg[SW-1] ? dx2_reg : '0;
        dx_hi   = dx2_reg[SW-1] ? '0 : dx2_reg;
        dy_lo   = dy2_reg[SW-1] ? dy2_reg : '0;
        dy_hi   = dy2_reg[SW-1] ? '0 : dy2_reg;
        broad_next = !(dx_lo > s_or_ml || dx_hi < s_ol_mr ||
                       dy_lo > s_ob_mt || dy_hi < s_ot_mb);
        ovl_next   = or_ml_reg >= 0 && ol_mr_reg <= 0 &&
                     ob_mt_reg >= 0 && ot_mb_reg <= 0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xin_reg   <= dx2_reg[SW-1] ? s_or_ml : s_ol_mr;
            xout_reg  <= dx2_reg[SW-1] ? s_ol_mr : s_or_ml;
            yin_reg   <= dy2_reg[SW-1] ? s_ob_mt : s_ot_mb;
            yout_reg  <= dy2_reg[SW-1] ? s_ot_mb : s_ob_mt;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            broad_reg <= broad_next;
            ovl_reg   <= ovl_next;
        end
    end

    function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] n;
        n = -v;
        return v[SW-1] ? n[MW-1:0] : v[MW-1:0];
    endfunction

    always_comb begin
        axin = mag(xin_reg);
        ayin = mag(yin_reg);
    end

    // stage 4: divider operands
    always_ff @(posedge aclk) begin
        if (en) begin
            xin_mag   <= axin;
            xout_mag  <= mag(xout_reg);
            yin_mag   <= ayin;
            yout_mag  <= mag(yout_reg);
            dx_mag    <= mag(dx3_reg);
            dy_mag    <= mag(dy3_reg);
            xin_qneg  <= xin_reg[SW-1] != dx3_reg[SW-1];
            xout_qneg <= xout_reg[SW-1] != dx3_reg[SW-1];
            yin_qneg  <= yin_reg[SW-1] != dy3_reg[SW-1];
            yout_qneg <= yout_reg[SW-1] != dy3_reg[SW-1];
            side.broad       <= broad_reg;
            side.overlap_now <= ovl_reg;
            side.dx_zero     <= dx3_reg == 0;
            side.dx_neg      <= dx3_reg[SW-1];
            side.dy_zero     <= dy3_reg == 0;
            side.dy_neg      <= dy3_reg[SW-1];
            side.xin_zero    <= xin_reg == 0;
            side.xin_neg     <= xin_reg[SW-1];
            side.yin_zero    <= yin_reg == 0;
            side.yin_neg     <= yin_reg[SW-1];
            side.xin_thin    <= {{(64-MW){1'b0}}, axin} < PIXEL;
            side.yin_thin    <= {{(64-MW){1'b0}}, ayin} < PIXEL;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sac_div.sv
// ----------------------------------------------------------------------------
// sac_div
// Pipelined restoring divider: floor quotient, 16 fraction bits, +-2.0 clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_div #(
    parameter int W = sac_pkg::COORD_WIDTH_DEF + 17
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [W-1:0]                      num_mag,
    input  wire logic [W-1:0]                      den_mag,
    input  wire logic                              neg,
    output logic signed [sac_pkg::TIME_W-1:0]      quot
);
    import sac_pkg::*;

    logic [W-1:0]      rem_reg [0:DIV_STEPS];
    logic [W-1:0]      den_reg [0:DIV_STEPS];
    logic [QUOT_W-1:0] q_reg   [0:DIV_STEPS];
    logic              neg_reg [0:DIV_STEPS];
    logic              sat_reg [0:DIV_STEPS];

    logic ge0;
    assign ge0 = num_mag >= den_mag;

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg[0] <= {1'b0, num_mag} >= {den_mag, 1'b0};
            rem_reg[0] <= ge0 ? num_mag - den_mag : num_mag;
            q_reg[0]   <= QUOT_W'(ge0);
            den_reg[0] <= den_mag;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [W:0] rs, rd;
        logic       ge;
        always_comb begin
            rs = {rem_reg[k-1], 1'b0};
            ge = rs >= {1'b0, den_reg[k-1]};
            rd = rs - {1'b0, den_reg[k-1]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? rd[W-1:0] : rs[W-1:0];
                q_reg[k]   <= {q_reg[k-1][QUOT_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    logic signed [TIME_W-1:0] qpos, qrnd;
    always_comb begin
        qpos = $signed(TIME_W'(q_reg[DIV_STEPS]));
        // negative quotients round toward minus infinity
        qrnd = qpos + $signed(TIME_W'(rem_reg[DIV_STEPS] != '0));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sat_reg[DIV_STEPS]) begin
                quot <= neg_reg[DIV_STEPS] ? -T_SAT : T_SAT;
            end else begin
                quot <= neg_reg[DIV_STEPS] ? -qrnd : qpos;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sac_resolve.sv
// ----------------------------------------------------------------------------
// sac_resolve
// Entry/exit interval test, face normal and overlap fallback (2 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module sac_resolve (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [sac_pkg::TIME_W-1:0] xe_q,
    input  wire logic signed [sac_pkg::TIME_W-1:0] xx_q,
    input  wire logic signed [sac_pkg::TIME_W-1:0] ye_q,
    input  wire logic signed [sac_pkg::TIME_W-1:0] yx_q,
    input  wire sac_pkg::side_t                    side,
    output logic [sac_pkg::HIT_W-1:0]              hit_time,
    output sac_pkg::norm_t                         normal_x,
    output sac_pkg::norm_t                         normal_y,
    output logic                                   already_overlapping
);
    import sac_pkg::*;

    logic signed [TIME_W-1:0] xe, xx, ye, yx, te, tx;
    logic                     miss;

    always_comb begin
        xe   = side.dx_zero ? -T_INF : xe_q;
        xx   = side.dx_zero ?  T_INF : xx_q;
        ye   = side.dy_zero ? -T_INF : ye_q;
        yx   = side.dy_zero ?  T_INF : yx_q;
        te   = xe > ye ? xe : ye;
        tx   = xx < yx ? xx : yx;
        miss = !side.broad || te > tx || (xe < 0 && ye < 0) ||
               xe > T_ONE || ye > T_ONE;
    end

    logic signed [TIME_W-1:0] te_reg;
    logic                     xfirst_reg, miss_reg;
    side_t                    side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            te_reg     <= te;
            xfirst_reg <= xe > ye;
            miss_reg   <= miss;
            side_reg   <= side;
        end
    end

    logic  hit;
    norm_t nx, ny;

    always_comb begin
        nx  = NORM_ZERO;
        ny  = NORM_ZERO;
        hit = !miss_reg && te_reg != T_ONE;
        if (xfirst_reg) begin
            hit = hit && !side_reg.yin_thin;
            // touching face: normal opposes the motion
            if (side_reg.xin_zero) begin
                nx = side_reg.dx_neg ? NORM_POS : NORM_NEG;
            end else begin
                nx = side_reg.xin_neg ? NORM_POS : NORM_NEG;
            end
        end else begin
            hit = hit && !side_reg.xin_thin;
            if (side_reg.yin_zero) begin
                ny = side_reg.dy_neg ? NORM_POS : NORM_NEG;
            end else begin
                ny = side_reg.yin_neg ? NORM_POS : NORM_NEG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (hit) begin
                hit_time            <= te_reg[HIT_W-1:0];
                normal_x            <= nx;
                normal_y            <= ny;
                already_overlapping <= 1'b0;
            end else begin
                hit_time            <= side_reg.overlap_now ? '0 : T_ONE[HIT_W-1:0];
                normal_x            <= NORM_ZERO;
                normal_y            <= NORM_ZERO;
                already_overlapping <= side_reg.overlap_now;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swept_aabb_collision_core.sv
// ----------------------------------------------------------------------------
// swept_aabb_collision_core
// Swept box-pair collision test, fully pipelined, one pair per unstalled clock.
// ----------------------------------------------------------------------------
//  channel   dir  signals                      contents
//  s_        in   tvalid tready tdata          box pair request
//  m_        out  tvalid tready tdata          hit time, normal, overlap
//  cfg_      in   we wdata                     step_time
//
//  4 front stages, 18 divider stages, 2 resolve stages (the last is the
//  output register). One request enters per cycle while the pipe advances.
//  All stages advance together whenever the output register is empty or
//  being taken; s_tready follows that, so a stall freezes the whole pipe.
//  aresetn clears the valid line and loads step_time with its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_aabb_collision_core #(
    parameter int COORD_WIDTH = sac_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sac_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [sac_pkg::STEP_W-1:0]          cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // mover_x, mover_y, mover_width, mover_height, mover_vel_x, mover_vel_y,
    // other_x, other_y, other_width, other_height, other_vel_x, other_vel_y
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // hit_time[16:0], normal_x[18:17], normal_y[20:19], already_overlapping[21]
    output logic [sac_pkg::OUT_W-1:0]                m_tdata
);
    import sac_pkg::*;

    localparam int MW  = COORD_WIDTH + 17;
    localparam int LAT = 4 + DIV_LAT + 2;

    logic [STEP_W-1:0] step_time_reg;
    logic              vld_reg [0:LAT-1];
    logic              adv;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= STEP_RESET;
        end else if (cfg_we) begin
            step_time_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    logic [MW-1:0] xin_mag, xout_mag, yin_mag, yout_mag, dx_mag, dy_mag;
    logic          xin_qneg, xout_qneg, yin_qneg, yout_qneg;
    side_t         side_front;

    sac_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk         (aclk),
        .en           (adv),
        .step_time    (step_time_reg),
        .mover_x      (s_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
        .mover_y      (s_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
        .mover_width  (s_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
        .mover_height (s_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
        .mover_vel_x  (s_tdata[4*COORD_WIDTH +: COORD_WIDTH]),
        .mover_vel_y  (s_tdata[5*COORD_WIDTH +: COORD_WIDTH]),
        .other_x      (s_tdata[6*COORD_WIDTH +: COORD_WIDTH]),
        .other_y      (s_tdata[7*COORD_WIDTH +: COORD_WIDTH]),
        .other_width  (s_tdata[8*COORD_WIDTH +: COORD_WIDTH]),
        .other_height (s_tdata[9*COORD_WIDTH +: COORD_WIDTH]),
        .other_vel_x  (s_tdata[10*COORD_WIDTH +: COORD_WIDTH]),
        .other_vel_y  (s_tdata[11*COORD_WIDTH +: COORD_WIDTH]),
        .xin_mag      (xin_mag),
        .xout_mag     (xout_mag),
        .yin_mag      (yin_mag),
        .yout_mag     (yout_mag),
        .dx_mag       (dx_mag),
        .dy_mag       (dy_mag),
        .xin_qneg     (xin_qneg),
        .xout_qneg    (xout_qneg),
        .yin_qneg     (yin_qneg),
        .yout_qneg    (yout_qneg),
        .side         (side_front)
    );

    logic signed [TIME_W-1:0] xe_q, xx_q, ye_q, yx_q;

    sac_div #(.W(MW)) u_div_xe (
        .aclk(aclk), .en(adv), .num_mag(xin_mag), .den_mag(dx_mag),
        .neg(xin_qneg), .quot(xe_q)
    );
    sac_div #(.W(MW)) u_div_xx (
        .aclk(aclk), .en(adv), .num_mag(xout_mag), .den_mag(dx_mag),
        .neg(xout_qneg), .quot(xx_q)
    );
    sac_div #(.W(MW)) u_div_ye (
        .aclk(aclk), .en(adv), .num_mag(yin_mag), .den_mag(dy_mag),
        .neg(yin_qneg), .quot(ye_q)
    );
    sac_div #(.W(MW)) u_div_yx (
        .aclk(aclk), .en(adv), .num_mag(yout_mag), .den_mag(dy_mag),
        .neg(yout_qneg), .quot(yx_q)
    );

    // flags ride alongside the dividers
    side_t side_dly_reg [0:DIV_LAT-1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_dly_reg[0] <= side_front;
            for (int i = 1; i < DIV_LAT; i++) side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    logic [HIT_W-1:0] hit_time;
    norm_t            normal_x, normal_y;
    logic             already_overlapping;

    sac_resolve u_resolve (
        .aclk                (aclk),
        .en                  (adv),
        .xe_q                (xe_q),
        .xx_q                (xx_q),
        .ye_q                (ye_q),
        .yx_q                (yx_q),
        .side                (side_dly_reg[DIV_LAT-1]),
        .hit_time            (hit_time),
        .normal_x            (normal_x),
        .normal_y            (normal_y),
        .already_overlapping (already_overlapping)
    );

    assign m_tdata = {2'b00, already_overlapping, normal_y, normal_x, hit_time};

endmodule

`default_nettype wire

FILE: hdl/sac_checker.sv
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks for the swept box collision core.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [sac_pkg::OUT_W-1:0]   m_tdata
);
    import sac_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("request ready not tied to output slot");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[HIT_W-1:0] <= T_ONE[HIT_W-1:0])
        else $error("hit time out of range");

    a_overlap_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tdata[20:0] == '0)
        else $error("overlap result not zero time and normal");

endmodule

bind swept_aabb_collision_core sac_checker u_sac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
